// ===== rtl/necir_pkg.sv =====
// Shared types, codes and window helpers for the NEC IR frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package necir_pkg;

  // Frame phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_MARK  = 3'd1;
  localparam logic [2:0] PH_SPACE = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_INV   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_MARGIN_UNIT    = 1'b1;

  localparam logic [15:0] DEVICE_ADDRESS_RST = 16'h50B8;
  localparam logic [8:0]  MARGIN_UNIT_RST    = 9'd130;

  localparam int ADDR_BITS = 16;
  localparam int BYTE_BITS = 8;

  // Nominal timings in microseconds, signed for the window maths
  localparam logic signed [18:0] T_LEADER_MARK  = 19'sd9000;
  localparam logic signed [18:0] T_LEADER_SPACE = 19'sd4500;
  localparam logic signed [18:0] T_BIT_ONE      = 19'sd2250;
  localparam logic signed [18:0] T_BIT_ZERO     = 19'sd1125;

  typedef struct packed {
    logic leader_mark;
    logic leader_space;
    logic addr_zero;
    logic addr_one;
    logic cmd_zero;
    logic cmd_one;
  } win_hits_t;

  typedef struct packed {
    logic       next_edge_rising;
    logic       key_valid;
    logic [7:0] key_code;
  } step_result_t;

  // Strict window test: centre - lo_k*m < t < centre + hi_k*m
  function automatic logic fits_window(input logic [15:0] t, input logic [8:0] m,
                                       input logic signed [18:0] centre,
                                       input logic [3:0] lo_k, input logic [3:0] hi_k);
    logic [12:0]        prod_lo;
    logic [12:0]        prod_hi;
    logic signed [18:0] v;
    logic signed [18:0] lo_bound;
    logic signed [18:0] hi_bound;
    prod_lo  = 13'(m) * 13'(lo_k);
    prod_hi  = 13'(m) * 13'(hi_k);
    v        = signed'({3'b000, t});
    lo_bound = centre - signed'({6'b000000, prod_lo});
    hi_bound = centre + signed'({6'b000000, prod_hi});
    return (v > lo_bound) && (v < hi_bound);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/nec_ir_frame_decoder_unit.sv =====
// Top level of the NEC IR frame decoder.
`timescale 1ns / 1ps
`default_nettype none
// NEC infrared frame decoder.
// Input channel: one request per captured edge, carrying in_pulse_width, the
//   time in microseconds since the previous edge. A request is taken on a
//   rising clk edge with in_valid high and in_stall low.
// Result channel: exactly one result per request, in order: the capture
//   polarity for the next edge, a key-valid flag and the command byte (zero
//   unless key-valid). Taken when out_valid is high and out_stall low.
// Config port: cfg_wr_en with cfg_index 0 writes the 16-bit device address,
//   index 1 the 9-bit margin unit (cfg_wdata[8:0]). Write only while idle.
// Timing: the request lands in an input register; one pass of window
//   compares and shifter updates fills the result register. The result
//   register takes the input register's result whenever it is empty or
//   being drained; throughput is one request per cycle while out_stall
//   is low.
// Stall: while out_stall holds a result, the input register keeps its
//   request and in_stall rises only once that register is occupied, so one
//   more request is absorbed before the input side is held off.
// Reset (synchronous, rst_n low): phase idle, shifters and counter cleared,
//   polarity falling, address 0x50B8, margin 130 us, both channels empty.
module nec_ir_frame_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pulse_width,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_next_edge_rising,
  output logic             out_key_valid,
  output logic      [7:0]  out_key_code,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  import necir_pkg::*;

  logic [15:0]  device_address;
  logic [8:0]   margin_unit;
  win_hits_t    hits;
  step_result_t step_res;

  // input register
  logic         s1_valid_r;
  logic [15:0]  s1_width_r;
  // result register
  logic         out_valid_r;
  step_result_t out_res_r;

  logic         advance;
  logic         step;
  logic         in_take;

  // result register frees up when empty or being drained this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  necir_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .device_address (device_address),
    .margin_unit    (margin_unit)
  );

  necir_width_check u_check (
    .pulse_width (s1_width_r),
    .margin_unit (margin_unit),
    .hits        (hits)
  );

  necir_frame_fsm u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .hits           (hits),
    .device_address (device_address),
    .result         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_width_r <= in_pulse_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_next_edge_rising = out_res_r.next_edge_rising;
  assign out_key_valid        = out_res_r.key_valid;
  assign out_key_code         = out_res_r.key_code;

`ifndef NO_ASSERTIONS
  a_key_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.key_valid) |-> !out_res_r.next_edge_rising)
    else $error("key reported without returning to falling capture");

  a_code_zero_without_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.key_valid) |-> (out_res_r.key_code == 8'h00))
    else $error("key code set without a key");

  a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed request did not reach the result register");
`endif

endmodule
`default_nettype wire

// ===== rtl/necir_cfg_regs.sv =====
// Configuration registers: device address and margin unit.
`timescale 1ns / 1ps
`default_nettype none
module necir_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output logic      [15:0] device_address,
  output logic      [8:0]  margin_unit
);
  import necir_pkg::*;

  logic [15:0] device_address_r;
  logic [8:0]  margin_unit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= DEVICE_ADDRESS_RST;
      margin_unit_r    <= MARGIN_UNIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_wdata;
        CFG_MARGIN_UNIT:    margin_unit_r    <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign device_address = device_address_r;
  assign margin_unit    = margin_unit_r;

endmodule
`default_nettype wire

// ===== rtl/necir_width_check.sv =====
// Pulse width window checks against the margin-scaled NEC timings.
`timescale 1ns / 1ps
`default_nettype none
module necir_width_check (
  input  wire logic [15:0]        pulse_width,
  input  wire logic [8:0]         margin_unit,
  output necir_pkg::win_hits_t    hits
);
  import necir_pkg::*;

  always_comb begin
    hits.leader_mark  = fits_window(pulse_width, margin_unit, T_LEADER_MARK, 4'd8, 4'd8);
    hits.leader_space = fits_window(pulse_width, margin_unit, T_LEADER_SPACE, 4'd4, 4'd4);
    // address and command bits use different margins, asymmetric except for command zero
    hits.addr_zero    = fits_window(pulse_width, margin_unit, T_BIT_ZERO, 4'd3, 4'd4);
    hits.addr_one     = fits_window(pulse_width, margin_unit, T_BIT_ONE, 4'd2, 4'd3);
    hits.cmd_zero     = fits_window(pulse_width, margin_unit, T_BIT_ZERO, 4'd3, 4'd3);
    hits.cmd_one      = fits_window(pulse_width, margin_unit, T_BIT_ONE, 4'd3, 4'd4);
  end

endmodule
`default_nettype wire

// ===== rtl/necir_frame_fsm.sv =====
// Frame phase machine with the address, command and inverse shifters.
`timescale 1ns / 1ps
`default_nettype none
module necir_frame_fsm (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire necir_pkg::win_hits_t   hits,
  input  wire logic [15:0]            device_address,
  output necir_pkg::step_result_t     result
);
  import necir_pkg::*;

  logic [2:0]  phase_r,   phase_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [15:0] addr_r,    addr_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [7:0]  inv_r,     inv_nxt;
  logic        pol_r,     pol_nxt;

  logic        bit_ok;
  logic        bit_val;
  logic [4:0]  cnt_inc;
  logic [15:0] addr_shifted;
  logic [7:0]  cmd_shifted;
  logic [7:0]  inv_shifted;
  logic        key_valid;
  logic [7:0]  key_code;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    inv_nxt     = inv_r;
    pol_nxt     = pol_r;
    key_valid   = 1'b0;
    key_code    = 8'h00;
    bit_ok      = 1'b0;
    bit_val     = 1'b0;
    cnt_inc      = bit_cnt_r + 5'd1;
    addr_shifted = 16'h0000;
    cmd_shifted  = 8'h00;
    inv_shifted  = 8'h00;

    case (phase_r)
      PH_MARK: begin
        pol_nxt   = 1'b0;
        phase_nxt = hits.leader_mark ? PH_SPACE : PH_IDLE;
      end
      PH_SPACE: begin
        if (hits.leader_space) begin
          phase_nxt   = PH_ADDR;
          addr_nxt    = 16'h0000;
          bit_cnt_nxt = 5'd0;
        end else begin
          phase_nxt = PH_IDLE;
          pol_nxt   = 1'b0;
        end
      end
      PH_ADDR: begin
        // zero wins where the two windows overlap
        bit_ok  = hits.addr_zero || hits.addr_one;
        bit_val = !hits.addr_zero;
        addr_shifted = {addr_r[14:0], bit_val};
        if (!bit_ok) begin
          phase_nxt = PH_IDLE;
          pol_nxt   = 1'b0;
        end else begin
          addr_nxt    = addr_shifted;
          bit_cnt_nxt = cnt_inc;
          if (cnt_inc == 5'(ADDR_BITS)) begin
            if (addr_shifted != device_address) begin
              phase_nxt = PH_IDLE;
              pol_nxt   = 1'b0;
            end else begin
              phase_nxt   = PH_CMD;
              bit_cnt_nxt = 5'd0;
            end
          end
        end
      end
      PH_CMD, PH_INV: begin
        // counter advances even on a bad width
        bit_cnt_nxt = cnt_inc;
        bit_ok      = hits.cmd_zero || hits.cmd_one;
        bit_val     = !hits.cmd_zero;
        cmd_shifted = {cmd_r[6:0], bit_val};
        inv_shifted = {inv_r[6:0], bit_val};
        if (!bit_ok) begin
          phase_nxt = PH_IDLE;
          pol_nxt   = 1'b0;
        end else if (phase_r == PH_CMD) begin
          cmd_nxt = cmd_shifted;
          if (cnt_inc == 5'(BYTE_BITS)) begin
            phase_nxt   = PH_INV;
            bit_cnt_nxt = 5'd0;
            inv_nxt     = 8'h00;
          end
        end else begin
          inv_nxt = inv_shifted;
          if (cnt_inc == 5'(BYTE_BITS)) begin
            phase_nxt = PH_IDLE;
            pol_nxt   = 1'b0;
            if (cmd_r == ~inv_shifted) begin
              key_valid = 1'b1;
              key_code  = cmd_r;
            end
          end
        end
      end
      default: begin
        // idle and unused codes: any width opens a frame
        pol_nxt   = 1'b1;
        phase_nxt = PH_MARK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      bit_cnt_r <= 5'd0;
      addr_r    <= 16'h0000;
      cmd_r     <= 8'h00;
      inv_r     <= 8'h00;
      pol_r     <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      addr_r    <= addr_nxt;
      cmd_r     <= cmd_nxt;
      inv_r     <= inv_nxt;
      pol_r     <= pol_nxt;
    end
  end

  assign result.next_edge_rising = pol_nxt;
  assign result.key_valid        = key_valid;
  assign result.key_code         = key_code;

`ifndef NO_ASSERTIONS
  a_rising_only_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    pol_r |-> (phase_r == PH_MARK))
    else $error("rising polarity outside leader mark phase");

  a_addr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (bit_cnt_r < 5'(ADDR_BITS)))
    else $error("address bit count overran");

  a_byte_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_CMD) || (phase_r == PH_INV)) |-> (bit_cnt_r < 5'(BYTE_BITS)))
    else $error("byte bit count overran");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_nec_ir_frame_decoder_unit.sv =====
// Self-checking testbench for the NEC IR frame decoder: frame traffic, window edges, stalls.
`timescale 1ns / 1ps
module tb;
  import necir_pkg::*;

  // Nominal NEC timings in microseconds, as plain ints for the window sums
  localparam int MARK_US   = 9000;
  localparam int SPACE_US  = 4500;
  localparam int ONE_US    = 2250;
  localparam int ZERO_US   = 1125;
  localparam int QUIET_MAX = 2000;  // idle cycles before the run is declared hung
  localparam int HOLD_LEN  = 300;   // long receiver hold-off in the pressure test
  localparam int LAST_SLOT = 34;    // idle edge, mark, space, 16 + 8 + 8 bits

  typedef enum int {
    FR_GOOD, FR_BAD_ADDR, FR_BAD_INV, FR_BAD_WIDTH, FR_TRUNC, FR_REPEAT
  } frame_kind_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_pulse_width;
  logic        out_valid;
  logic        out_stall;
  logic        out_next_edge_rising;
  logic        out_key_valid;
  logic [7:0]  out_key_code;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  nec_ir_frame_decoder_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pulse_width       (in_pulse_width),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_next_edge_rising (out_next_edge_rising),
    .out_key_valid        (out_key_valid),
    .out_key_code         (out_key_code),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // Decoder mirror: configuration and frame state as the block should hold them
  logic [15:0] dev_addr = DEVICE_ADDRESS_RST;
  logic [8:0]  margin   = MARGIN_UNIT_RST;
  logic [2:0]  phase    = PH_IDLE;
  logic [4:0]  bit_cnt  = '0;
  logic [15:0] addr_sr  = '0;
  logic [7:0]  cmd_sr   = '0;
  logic [7:0]  inv_sr   = '0;
  logic        pol      = 1'b0;   // 1: capture rising edge next

  step_result_t pending_steps[$];  // one expected result per accepted request
  int           errors       = 0;
  int           quiet_cycles = 0;
  int           burst_left   = 0;
  bit           gaps_on      = 1'b1;
  int           hold_req     = 0;  // picked up by the receiver process

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the decoder
  // ---------------------------------------------------------------------------

  // Strict window test; bounds are signed so a negative lower bound admits zero
  function automatic bit in_window(input logic [15:0] w, input int centre,
                                   input int lo_k, input int hi_k);
    int m;
    m = int'(margin);
    return int'(w) > centre - lo_k * m && int'(w) < centre + hi_k * m;
  endfunction

  function automatic void drop_frame();
    phase = PH_IDLE;
    pol   = 1'b0;
  endfunction

  // Advance the mirror by one captured edge and queue the result it must give
  function automatic void decode_edge(input logic [15:0] w);
    step_result_t r;
    logic         b;
    bit           ok;
    r  = '0;
    b  = 1'b0;
    ok = 1'b1;
    case (phase)
      PH_MARK: begin
        pol   = 1'b0;
        phase = in_window(w, MARK_US, 8, 8) ? PH_SPACE : PH_IDLE;
      end
      PH_SPACE: begin
        // a repeat space lands here too and drops the frame unless the margin takes it as a leader space
        if (in_window(w, SPACE_US, 4, 4)) begin
          phase   = PH_ADDR;
          addr_sr = '0;
          bit_cnt = '0;
        end else begin
          drop_frame();
        end
      end
      PH_ADDR: begin
        // zero wins where the two windows overlap
        if (in_window(w, ZERO_US, 3, 4)) b = 1'b0;
        else if (in_window(w, ONE_US, 2, 3)) b = 1'b1;
        else ok = 1'b0;
        if (!ok) begin
          drop_frame();
        end else begin
          addr_sr = {addr_sr[14:0], b};
          bit_cnt = bit_cnt + 5'd1;
          if (bit_cnt == 5'(ADDR_BITS)) begin
            if (addr_sr != dev_addr) begin
              drop_frame();
            end else begin
              phase   = PH_CMD;
              bit_cnt = '0;
            end
          end
        end
      end
      PH_CMD, PH_INV: begin
        // counter moves before the width is judged
        bit_cnt = bit_cnt + 5'd1;
        if (in_window(w, ZERO_US, 3, 3)) b = 1'b0;
        else if (in_window(w, ONE_US, 3, 4)) b = 1'b1;
        else ok = 1'b0;
        if (!ok) begin
          drop_frame();
        end else if (phase == PH_CMD) begin
          cmd_sr = {cmd_sr[6:0], b};
          if (bit_cnt == 5'(BYTE_BITS)) begin
            phase   = PH_INV;
            bit_cnt = '0;
            inv_sr  = '0;
          end
        end else begin
          inv_sr = {inv_sr[6:0], b};
          if (bit_cnt == 5'(BYTE_BITS)) begin
            drop_frame();
            if (cmd_sr == ~inv_sr) begin
              r.key_valid = 1'b1;
              r.key_code  = cmd_sr;
            end
          end
        end
      end
      default: begin
        // idle and spare codes: any width opens a frame
        pol   = 1'b1;
        phase = PH_MARK;
      end
    endcase
    r.next_edge_rising = pol;
    pending_steps.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Width generators (frame widths follow the current margin)
  // ---------------------------------------------------------------------------

  // Width strictly between lo_b and hi_b, often on the very edge; the midpoint if the window is empty
  function automatic logic [15:0] pick_in(input int lo_b, input int hi_b);
    int lo;
    int hi;
    lo = (lo_b + 1 < 0) ? 0 : lo_b + 1;
    hi = (hi_b - 1 > 65535) ? 65535 : hi_b - 1;
    if (lo > hi) return 16'((lo_b + hi_b) / 2);  // empty window (margin 0)
    case ($urandom_range(0, 3))
      0:       return 16'(lo);
      1:       return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // A one bit kept clear of the zero window where the margin allows it
  function automatic logic [15:0] pick_one(input int zero_hi, input int one_lo,
                                           input int one_hi);
    return pick_in((zero_hi - 1 > one_lo) ? zero_hi - 1 : one_lo, one_hi);
  endfunction

  // Width that misses the window: on a bound or far too long
  function automatic logic [15:0] off_window(input int lo_b, input int hi_b);
    case ($urandom_range(0, 2))
      0:       return (lo_b >= 0) ? 16'(lo_b) : 16'(hi_b);
      1:       return 16'(hi_b);
      default: return 16'($urandom_range(65535, 14000));
    endcase
  endfunction

  // Width for one slot of a frame: idle edge, leader mark, leader space, bits
  function automatic logic [15:0] frame_width(input int slot, input logic [15:0] a,
                                              input logic [7:0] c, input logic [7:0] ic,
                                              input bit broken);
    int   m;
    logic b;
    m = int'(margin);
    if (slot == 0) return 16'($urandom);
    if (slot == 1) begin
      if (broken) return off_window(MARK_US - 8 * m, MARK_US + 8 * m);
      return pick_in(MARK_US - 8 * m, MARK_US + 8 * m);
    end
    if (slot == 2) begin
      if (broken) return off_window(SPACE_US - 4 * m, SPACE_US + 4 * m);
      return pick_in(SPACE_US - 4 * m, SPACE_US + 4 * m);
    end
    if (slot < 19) begin
      b = a[18 - slot];  // address MSB first
      if (broken) return off_window(ZERO_US - 3 * m, ONE_US + 3 * m);
      if (b) return pick_one(ZERO_US + 4 * m, ONE_US - 2 * m, ONE_US + 3 * m);
      return pick_in(ZERO_US - 3 * m, ZERO_US + 4 * m);
    end
    b = (slot < 27) ? c[26 - slot] : ic[34 - slot];
    if (broken) return off_window(ZERO_US - 3 * m, ONE_US + 4 * m);
    if (b) return pick_one(ZERO_US + 3 * m, ONE_US - 3 * m, ONE_US + 4 * m);
    return pick_in(ZERO_US - 3 * m, ZERO_US + 3 * m);
  endfunction

  function automatic logic [15:0] noise_width();
    int centre;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3000, 0));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        case ($urandom_range(0, 3))
          0:       centre = MARK_US;
          1:       centre = SPACE_US;
          2:       centre = ONE_US;
          default: centre = ZERO_US;
        endcase
        return 16'(centre + int'($urandom_range(1200, 0)) - 600);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request; bursts of random length with random gaps between them while gaps_on is set
  task automatic send_width(input logic [15:0] w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = gaps_on ? $urandom_range(6, 0) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_pulse_width <= w;
    do @(posedge clk); while (in_stall);
    decode_edge(w);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic [15:0] a;
    logic [7:0]  c;
    logic [7:0]  ic;
    int          cut;
    int          last;
    int          slot;
    int          m;
    a    = dev_addr;
    c    = 8'($urandom);
    ic   = ~c;
    cut  = LAST_SLOT + 1;
    last = LAST_SLOT;
    m    = int'(margin);
    case (kind)
      FR_BAD_ADDR:  a    = a ^ 16'($urandom_range(65535, 1));
      FR_BAD_INV:   ic   = ic ^ 8'($urandom_range(255, 1));
      FR_BAD_WIDTH: cut  = $urandom_range(LAST_SLOT, 1);
      FR_TRUNC:     last = $urandom_range(LAST_SLOT - 1, 1);
      FR_REPEAT:    last = 2;
      default: ;
    endcase
    // an over-long width drops any frame in progress at every margin
    if (phase != PH_IDLE) send_width(16'hFFFF);
    for (slot = 0; slot <= last; slot++) begin
      if (kind == FR_REPEAT && slot == 2)
        send_width(pick_in(ONE_US - 2 * m, ONE_US + 2 * m));
      else
        send_width(frame_width(slot, a, c, ic, slot == cut));
    end
  endtask

  // Sender pause: every expected result back, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_DEVICE_ADDRESS) dev_addr = data;
    else margin = data[8:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Upper data bits are junk on a margin write and must be ignored
  task automatic configure(input logic [15:0] a, input logic [8:0] m);
    write_reg(CFG_DEVICE_ADDRESS, a);
    write_reg(CFG_MARGIN_UNIT, {7'($urandom), m});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-built sequence on the reset margin: leader and address bit windows
  // probed on and just inside their bounds, plus a repeat frame
  task automatic test_window_edges();
    int m;
    m = int'(margin);
    send_width(16'h0000);                      // idle: any width opens a frame
    send_width(16'(MARK_US - 8 * m));          // on the lower bound: dropped
    send_width(16'hFFFF);
    send_width(16'(MARK_US + 8 * m));          // on the upper bound: dropped
    send_width(16'h1234);
    send_width(16'(MARK_US - 8 * m + 1));
    send_width(16'(SPACE_US + 4 * m - 1));
    send_width(16'(ZERO_US - 3 * m + 1));      // lowest zero bit
    send_width(16'(ZERO_US + 4 * m - 1));      // highest zero bit
    send_width(16'(ONE_US + 3 * m - 1));       // highest one bit
    send_width(16'(ZERO_US + 4 * m));          // between the bit windows: dropped
    send_width(16'h0007);
    send_width(16'(MARK_US));
    send_width(16'(SPACE_US - 4 * m));         // space on its lower bound
    send_width(16'h8000);
    send_width(16'(MARK_US));
    send_width(16'(ONE_US));                   // repeat space ends the frame
    send_width(16'h0001);
    send_width(16'(MARK_US + 8 * m - 1));
    send_width(16'(SPACE_US - 4 * m + 1));
    send_width(16'(ONE_US - 2 * m));           // just below the one window
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic test_random_traffic(input int frames, input int noise);
    int          r;
    frame_kind_e kind;
    while (frames > 0 || noise > 0) begin
      if (noise > 0 && (frames == 0 || $urandom_range(2, 0) == 0)) begin
        send_width(noise_width());
        noise--;
      end else begin
        r = $urandom_range(9, 0);
        if (r < 6) kind = FR_GOOD;
        else if (r == 6) kind = FR_BAD_ADDR;
        else if (r == 7) kind = FR_BAD_INV;
        else if (r == 8) kind = $urandom_range(1, 0) ? FR_BAD_WIDTH : FR_TRUNC;
        else kind = FR_REPEAT;
        send_frame(kind);
        frames--;
      end
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block fills and pushes back on its input
  task automatic test_output_hold();
    hold_req = HOLD_LEN;
    send_frame(FR_GOOD);
    send_frame(FR_GOOD);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, re-chosen when the current pattern runs out of cycles
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int pat_mode;
    int pat_left;
    hold_left = 0;
    pat_mode  = 0;
    pat_left  = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(3, 0);
          pat_left = $urandom_range(96, 16);
        end
        pat_left--;
        case (pat_mode)
          0:       out_stall <= 1'b0;                        // free-running stretch
          1:       out_stall <= ($urandom_range(3, 0) == 0);
          2:       out_stall <= $urandom_range(1, 0);
          default: out_stall <= (pat_left % 5 < 3);          // periodic
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and activity count for the watchdog
  // ---------------------------------------------------------------------------
  function automatic void report_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_steps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with no request pending", $realtime);
        end else begin
          want = pending_steps.pop_front();
          report_field("next_edge_rising", 8'(want.next_edge_rising),
                       8'(out_next_edge_rising));
          report_field("key_valid", 8'(want.key_valid), 8'(out_key_valid));
          report_field("key_code", want.key_code, out_key_code);
        end
      end
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pulse_width = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_DEVICE_ADDRESS;
    cfg_wdata      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_window_edges();
    test_random_traffic(12, 60);

    // zero margin: every window is empty, nothing gets past the leader mark
    wait_idle();
    configure(16'h0000, 9'd0);
    test_random_traffic(2, 50);

    // widest margin: bit windows overlap and the zero window reaches zero
    wait_idle();
    configure(16'hFFFF, 9'd511);
    test_random_traffic(8, 30);

    // tightest useful margin
    wait_idle();
    configure(16'($urandom), 9'd1);
    test_random_traffic(6, 20);

    // mid-range margin with the sender never pausing
    wait_idle();
    configure(16'($urandom), 9'($urandom_range(380, 40)));
    gaps_on = 1'b0;
    test_random_traffic(6, 20);
    gaps_on = 1'b1;

    wait_idle();
    test_output_hold();

    wait_idle();
    configure(16'($urandom), 9'd400);
    test_random_traffic(6, 20);

    wait_idle();
    repeat (6) @(posedge clk);
    if (errors == 0 && pending_steps.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
